>>> hw/rtl/kpht_pkg.sv
// Types and constants shared by the k-mer pair hash table modules.
`default_nettype none
package kpht_pkg;

  localparam int unsigned SIZE_W  = 11;  // table size register width
  localparam int unsigned MULT_W  = 32;  // hash multiplier width
  localparam int unsigned KLEN_W  = 4;   // k-mer length register width
  localparam int unsigned KEY_W   = 64;  // one k-mer field
  localparam int unsigned ORDER_W = 32;  // insertion order counter
  localparam int unsigned SLOT_W  = 10;  // slot field of a result
  localparam int unsigned ATT_W   = SIZE_W + 1;
  localparam int unsigned PROD_W  = 2 * SIZE_W;  // h * (mult mod size) + base
  localparam int unsigned DVD_W   = 32;  // dividend width of the remainder unit
  localparam int unsigned NB_W    = 6;   // bit count of the remainder unit
  localparam int unsigned CIDX_W  = 2;

  localparam logic [CIDX_W-1:0] CFG_MULT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_SIZE = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_KLEN = 2'd2;

  localparam logic [MULT_W-1:0] MULT_RST = 32'd257;
  localparam logic [SIZE_W-1:0] SIZE_RST = 11'd1021;
  localparam logic [KLEN_W-1:0] KLEN_RST = 4'd8;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_EXISTS   = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MRED,
    S_MUL,
    S_HMOD,
    S_RD,
    S_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   src;
    logic [KEY_W-1:0]   dst;
    logic [ORDER_W-1:0] order;
  } entry_t;

  // request to the remainder unit
  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;  // left aligned
    logic [NB_W-1:0]   nbits;
    logic [SIZE_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [SIZE_W-1:0] rem;
  } rem_rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/kmer_pair_hash_table_core.sv
// Top level of the k-mer pair hash table: control, table memory, config.
//
// Open-addressing hash table keyed by a (source, destination) k-mer pair.
// For each item the shared bit-serial remainder unit first reduces the
// multiplier modulo the table size. Each of the 2k bases, where k is the
// effective k-mer length (up to 8), then takes a multiply step and a
// remainder reduction. Each probe, one per collision met plus the first,
// costs a table read and a compare. The result is then handed to the output
// register, waiting while that register stays full under a stalled result,
// and the block returns to idle. After reset the block sweeps the table once
// to clear the valid bits and holds in_stall_o high meanwhile; config writes
// are taken during the sweep. A finished result sits in an output register,
// so the next transfer is accepted while the last result waits.
`default_nettype none
module kmer_pair_hash_table_core #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned MAX_BASES   = 8
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // configuration
  input  wire                            cfg_we_i,
  input  wire [kpht_pkg::CIDX_W-1:0]     cfg_idx_i,
  input  wire [kpht_pkg::MULT_W-1:0]     cfg_data_i,
  // request channel
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire                            mode_i,
  input  wire [kpht_pkg::KEY_W-1:0]      source_kmer_i,
  input  wire [kpht_pkg::KEY_W-1:0]      dest_kmer_i,
  // result channel
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic [1:0]                     status_o,
  output logic [kpht_pkg::SLOT_W-1:0]    slot_o,
  output logic [kpht_pkg::ORDER_W-1:0]   order_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned SW = kpht_pkg::SIZE_W;

  // config registers
  logic [kpht_pkg::MULT_W-1:0] mult_q;
  logic [SW-1:0]               tsize_q;
  logic [kpht_pkg::KLEN_W-1:0] klen_q;

  // control
  kpht_pkg::state_e            state_q, state_d;
  logic [AW-1:0]               clr_q, clr_d;
  logic [kpht_pkg::ORDER_W-1:0] next_order_q, next_order_d;
  logic                        out_valid_q, out_valid_d;

  // item context
  logic                        mode_q, mode_d;
  logic [kpht_pkg::KEY_W-1:0]  src_q, src_d, dst_q, dst_d;
  logic [SW-1:0]               size_q, size_d;
  logic [kpht_pkg::KLEN_W-1:0] k_q, k_d;
  logic [SW-1:0]               mr_q, mr_d;
  logic [SW-1:0]               h_q, h_d, first_q, first_d, off_q, off_d;
  logic [2:0]                  bidx_q, bidx_d;
  logic                        phase_q, phase_d;
  logic [kpht_pkg::ATT_W-1:0]  att_q, att_d;
  kpht_pkg::status_e           res_st_q, res_st_d;
  logic [SW-1:0]               res_slot_q, res_slot_d;
  logic [kpht_pkg::ORDER_W-1:0] res_ord_q, res_ord_d;

  // output register
  kpht_pkg::status_e           o_st_q;
  logic [kpht_pkg::SLOT_W-1:0] o_slot_q;
  logic [kpht_pkg::ORDER_W-1:0] o_ord_q;
  logic                        out_load;

  // effective settings and key mask
  logic [SW-1:0]               eff_size;
  logic [kpht_pkg::KLEN_W-1:0] eff_k;
  logic [kpht_pkg::KEY_W-1:0]  kmask;

  // table memory
  kpht_pkg::entry_t            mem [TABLE_DEPTH];
  kpht_pkg::entry_t            rd_q, wdata;
  logic                        we;
  logic [AW-1:0]               waddr, raddr;

  // remainder unit
  kpht_pkg::rem_req_t          rreq;
  kpht_pkg::rem_rsp_t          rrsp;

  // datapath helpers
  logic [kpht_pkg::KEY_W-1:0]  key_cur;
  logic [7:0]                  base;
  logic [kpht_pkg::PROD_W-1:0] prod;
  logic                        match, stop;
  logic [SW:0]                 o1, o2, o3, s1, s2;
  logic [SW-1:0]               off_n, h_n;

  kpht_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rreq),
    .rsp_o  (rrsp)
  );

  // clamp table size to 1..TABLE_DEPTH and k to MAX_BASES
  always_comb begin
    if (tsize_q == '0) begin
      eff_size = SW'(1);
    end else if (32'(tsize_q) > 32'(TABLE_DEPTH)) begin
      eff_size = SW'(TABLE_DEPTH);
    end else begin
      eff_size = tsize_q;
    end
    if (32'(klen_q) > 32'(MAX_BASES)) begin
      eff_k = kpht_pkg::KLEN_W'(MAX_BASES);
    end else begin
      eff_k = klen_q;
    end
  end

  for (genvar j = 0; j < 8; j++) begin : g_mask
    assign kmask[j*8 +: 8] = (eff_k > kpht_pkg::KLEN_W'(j)) ? 8'hFF : 8'h00;
  end

  // hash step: h * (mult mod size) + base, reduced by the remainder unit
  assign key_cur = phase_q ? dst_q : src_q;
  assign base    = key_cur[bidx_q*8 +: 8];
  assign prod    = ({{SW{1'b0}}, h_q} * {{SW{1'b0}}, mr_q})
                 + {{(kpht_pkg::PROD_W-8){1'b0}}, base};

  // probe step: offset advances by two, slot by the offset, both mod size
  always_comb begin
    o1 = {1'b0, off_q} + (SW+1)'(2);
    o2 = (o1 >= {1'b0, size_q}) ? o1 - {1'b0, size_q} : o1;
    o3 = (o2 >= {1'b0, size_q}) ? o2 - {1'b0, size_q} : o2;
    off_n = o3[SW-1:0];
    s1 = {1'b0, h_q} + {1'b0, off_n};
    s2 = (s1 >= {1'b0, size_q}) ? s1 - {1'b0, size_q} : s1;
    h_n = s2[SW-1:0];
  end

  assign match = rd_q.valid && (rd_q.src == src_q) && (rd_q.dst == dst_q);
  assign stop  = !rd_q.valid || match;

  assign out_load = (state_q == kpht_pkg::S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    next_order_d = next_order_q;
    mode_d       = mode_q;
    src_d        = src_q;
    dst_d        = dst_q;
    size_d       = size_q;
    k_d          = k_q;
    mr_d         = mr_q;
    h_d          = h_q;
    first_d      = first_q;
    off_d        = off_q;
    bidx_d       = bidx_q;
    phase_d      = phase_q;
    att_d        = att_q;
    res_st_d     = res_st_q;
    res_slot_d   = res_slot_q;
    res_ord_d    = res_ord_q;
    rreq         = '0;
    rreq.divisor = size_q;
    we           = 1'b0;
    waddr        = AW'(h_q);
    wdata        = '0;

    case (state_q)
      kpht_pkg::S_CLEAR: begin
        // sweep the table, dropping every valid bit
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(TABLE_DEPTH - 1)) begin
          state_d = kpht_pkg::S_IDLE;
        end
      end
      kpht_pkg::S_IDLE: begin
        if (in_valid_i) begin
          mode_d        = mode_i;
          src_d         = source_kmer_i & kmask;
          dst_d         = dest_kmer_i & kmask;
          size_d        = eff_size;
          k_d           = eff_k;
          h_d           = '0;
          bidx_d        = '0;
          phase_d       = 1'b0;
          rreq.start    = 1'b1;
          rreq.dividend = mult_q;
          rreq.nbits    = kpht_pkg::NB_W'(kpht_pkg::MULT_W);
          rreq.divisor  = eff_size;
          state_d       = kpht_pkg::S_MRED;
        end
      end
      kpht_pkg::S_MRED: begin
        if (rrsp.done) begin
          mr_d = rrsp.rem;
          if (k_q == '0) begin
            first_d = h_q;
            att_d   = '0;
            off_d   = (size_q == SW'(1)) ? '0 : SW'(1);
            state_d = kpht_pkg::S_RD;
          end else begin
            state_d = kpht_pkg::S_MUL;
          end
        end
      end
      kpht_pkg::S_MUL: begin
        rreq.start    = 1'b1;
        rreq.dividend = {prod, {(kpht_pkg::DVD_W-kpht_pkg::PROD_W){1'b0}}};
        rreq.nbits    = kpht_pkg::NB_W'(kpht_pkg::PROD_W);
        state_d       = kpht_pkg::S_HMOD;
      end
      kpht_pkg::S_HMOD: begin
        if (rrsp.done) begin
          h_d = rrsp.rem;
          if ({1'b0, bidx_q} == k_q - kpht_pkg::KLEN_W'(1)) begin
            bidx_d = '0;
            if (phase_q) begin
              first_d = rrsp.rem;
              att_d   = '0;
              off_d   = (size_q == SW'(1)) ? '0 : SW'(1);
              state_d = kpht_pkg::S_RD;
            end else begin
              phase_d = 1'b1;
              state_d = kpht_pkg::S_MUL;
            end
          end else begin
            bidx_d  = bidx_q + 3'd1;
            state_d = kpht_pkg::S_MUL;
          end
        end
      end
      kpht_pkg::S_RD: begin
        // read address is h_q; data arrives next cycle
        state_d = kpht_pkg::S_CMP;
      end
      kpht_pkg::S_CMP: begin
        res_slot_d = '0;
        res_ord_d  = '0;
        if (stop) begin
          state_d = kpht_pkg::S_DONE;
          if (rd_q.valid) begin
            res_st_d   = mode_q ? kpht_pkg::ST_EXISTS : kpht_pkg::ST_OK;
            res_slot_d = h_q;
            res_ord_d  = rd_q.order;
          end else if (mode_q) begin
            we           = 1'b1;
            wdata.valid  = 1'b1;
            wdata.src    = src_q;
            wdata.dst    = dst_q;
            wdata.order  = next_order_q;
            next_order_d = next_order_q + kpht_pkg::ORDER_W'(1);
            res_st_d     = kpht_pkg::ST_OK;
            res_slot_d   = h_q;
            res_ord_d    = next_order_q;
          end else begin
            res_st_d = kpht_pkg::ST_NOTFOUND;
          end
        end else if ((att_q != '0 && h_q == first_q)
                     || att_q == {1'b0, size_q} + kpht_pkg::ATT_W'(1)) begin
          // wrapped around: no empty slot and no match
          res_st_d = mode_q ? kpht_pkg::ST_FULL : kpht_pkg::ST_NOTFOUND;
          state_d  = kpht_pkg::S_DONE;
        end else begin
          off_d   = off_n;
          h_d     = h_n;
          att_d   = att_q + kpht_pkg::ATT_W'(1);
          state_d = kpht_pkg::S_RD;
        end
      end
      kpht_pkg::S_DONE: begin
        if (out_load) begin
          state_d = kpht_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = kpht_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != kpht_pkg::S_IDLE);
  assign raddr      = AW'(h_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= kpht_pkg::S_CLEAR;
      clr_q        <= '0;
      next_order_q <= '0;
      out_valid_q  <= 1'b0;
      mult_q       <= kpht_pkg::MULT_RST;
      tsize_q      <= kpht_pkg::SIZE_RST;
      klen_q       <= kpht_pkg::KLEN_RST;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      next_order_q <= next_order_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kpht_pkg::CFG_MULT: mult_q  <= cfg_data_i;
          kpht_pkg::CFG_SIZE: tsize_q <= cfg_data_i[SW-1:0];
          kpht_pkg::CFG_KLEN: klen_q  <= cfg_data_i[kpht_pkg::KLEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // item context and result payload
  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    src_q      <= src_d;
    dst_q      <= dst_d;
    size_q     <= size_d;
    k_q        <= k_d;
    mr_q       <= mr_d;
    h_q        <= h_d;
    first_q    <= first_d;
    off_q      <= off_d;
    bidx_q     <= bidx_d;
    phase_q    <= phase_d;
    att_q      <= att_d;
    res_st_q   <= res_st_d;
    res_slot_q <= res_slot_d;
    res_ord_q  <= res_ord_d;
    if (out_load) begin
      o_st_q   <= res_st_q;
      o_slot_q <= kpht_pkg::SLOT_W'(res_slot_q);
      o_ord_q  <= res_ord_q;
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = o_st_q;
  assign slot_o      = o_slot_q;
  assign order_o     = o_ord_q;

  a_write_only_clear_or_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == kpht_pkg::S_CLEAR || (state_q == kpht_pkg::S_CMP && mode_q)))
    else $error("table write outside clear or insert");
  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kpht_pkg::S_RD || state_q == kpht_pkg::S_CMP) |-> (h_q < size_q))
    else $error("probe slot beyond table size");
  a_order_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_order_q != $past(next_order_q)) |-> ($past(we) && $past(state_q) == kpht_pkg::S_CMP))
    else $error("order counter moved without an insert");

endmodule
`default_nettype wire

>>> hw/rtl/kpht_rem.sv
// Bit-serial remainder unit: one dividend bit per cycle, restoring.
`default_nettype none
module kpht_rem (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  kpht_pkg::rem_req_t   req_i,
  output kpht_pkg::rem_rsp_t   rsp_o
);

  logic [kpht_pkg::DVD_W-1:0]  sh_q;
  logic [kpht_pkg::NB_W-1:0]   cnt_q;
  logic [kpht_pkg::SIZE_W-1:0] r_q, div_q, r_n;
  logic                        busy_q, done_q;
  logic [kpht_pkg::SIZE_W:0]   t;

  // shift in next bit, subtract divisor when it fits
  always_comb begin
    t = {r_q, sh_q[kpht_pkg::DVD_W-1]};
    if (t >= {1'b0, div_q}) begin
      t = t - {1'b0, div_q};
    end
    r_n = t[kpht_pkg::SIZE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == kpht_pkg::NB_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sh_q  <= req_i.dividend;
      cnt_q <= req_i.nbits;
      div_q <= req_i.divisor;
      r_q   <= '0;
    end else if (busy_q) begin
      sh_q  <= {sh_q[kpht_pkg::DVD_W-2:0], 1'b0};
      cnt_q <= cnt_q - kpht_pkg::NB_W'(1);
      r_q   <= r_n;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = r_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start) else $error("remainder restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without a running division");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (r_q < div_q)) else $error("remainder not below divisor");

endmodule
`default_nettype wire

>>> test/kmer_pair_hash_table_core_test.sv
// Self-checking testbench for the k-mer pair hash table core.
module kmer_pair_hash_table_core_test;

  typedef struct {
    kpht_pkg::status_e            st;
    logic [kpht_pkg::SLOT_W-1:0]  slot;
    logic [kpht_pkg::ORDER_W-1:0] ord;
  } outcome_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [kpht_pkg::CIDX_W-1:0]  cfg_idx_i = kpht_pkg::CFG_MULT;
  logic [kpht_pkg::MULT_W-1:0]  cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic                         mode_i = 1'b0;
  logic [kpht_pkg::KEY_W-1:0]   source_kmer_i = '0;
  logic [kpht_pkg::KEY_W-1:0]   dest_kmer_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [1:0]                   status_o;
  logic [kpht_pkg::SLOT_W-1:0]  slot_o;
  logic [kpht_pkg::ORDER_W-1:0] order_o;

  // Shadow copy of the table and its settings
  logic [kpht_pkg::MULT_W-1:0]  sh_mult = kpht_pkg::MULT_RST;
  logic [kpht_pkg::SIZE_W-1:0]  sh_size = kpht_pkg::SIZE_RST;
  logic [kpht_pkg::KLEN_W-1:0]  sh_klen = kpht_pkg::KLEN_RST;
  bit                           sh_valid [1024];
  logic [kpht_pkg::KEY_W-1:0]   sh_src [1024];
  logic [kpht_pkg::KEY_W-1:0]   sh_dst [1024];
  logic [kpht_pkg::ORDER_W-1:0] sh_ord [1024];
  logic [kpht_pkg::ORDER_W-1:0] sh_next = '0;

  outcome_t pending_results[$];
  int       errors = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_len = 0;
  logic     hold_on = 1'b0;
  event     hold_start;
  logic [kpht_pkg::KEY_W-1:0] key_pool [32];

  kmer_pair_hash_table_core u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .mode_i, .source_kmer_i, .dest_kmer_i,
    .out_valid_o, .out_stall_i, .status_o, .slot_o, .order_o
  );

  always #5 clk_i = ~clk_i;

  function automatic bit probe_ends(logic [63:0] s, logic [63:0] d, logic [63:0] at);
    if (!sh_valid[at]) return 1'b1;
    return sh_src[at] == s && sh_dst[at] == d;
  endfunction

  // Hash, probe and update the shadow table for one request
  function automatic outcome_t lookup_or_insert(bit m, logic [63:0] s, logic [63:0] d);
    logic [63:0] size, h, first, att, mask;
    int          k;
    bit          hit;
    outcome_t    r;
    size = (sh_size == 0) ? 64'd1 : ((sh_size > 1024) ? 64'd1024 : 64'(sh_size));
    k = (sh_klen > 8) ? 8 : int'(sh_klen);
    mask = (k >= 8) ? '1 : ((64'd1 << (8 * k)) - 64'd1);
    s = s & mask;
    d = d & mask;
    h = 0;
    for (int i = 0; i < k; i++) h = (h * 64'(sh_mult) + 64'(s[8*i +: 8])) % size;
    for (int i = 0; i < k; i++) h = (h * 64'(sh_mult) + 64'(d[8*i +: 8])) % size;
    hit = probe_ends(s, d, h);
    if (!hit) begin
      first = h;
      for (att = 1; att <= size + 1; att++) begin
        h = (h + 2 * att + 1) % size;
        if (probe_ends(s, d, h)) begin
          hit = 1'b1;
          break;
        end
        if (h == first) break;
      end
    end
    r.slot = '0;
    r.ord = '0;
    if (!hit) begin
      r.st = m ? kpht_pkg::ST_FULL : kpht_pkg::ST_NOTFOUND;
    end else if (sh_valid[h]) begin
      r.st = m ? kpht_pkg::ST_EXISTS : kpht_pkg::ST_OK;
      r.slot = h[kpht_pkg::SLOT_W-1:0];
      r.ord = sh_ord[h];
    end else if (m) begin
      sh_valid[h] = 1'b1;
      sh_src[h] = s;
      sh_dst[h] = d;
      sh_ord[h] = sh_next;
      r.st = kpht_pkg::ST_OK;
      r.slot = h[kpht_pkg::SLOT_W-1:0];
      r.ord = sh_next;
      sh_next = sh_next + 1;
    end else begin
      r.st = kpht_pkg::ST_NOTFOUND;
    end
    return r;
  endfunction

  // Offer one request, hold it until the transfer, then record the outcome
  task automatic send_request(bit m, logic [63:0] s, logic [63:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    source_kmer_i <= s;
    dest_kmer_i <= d;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_results.push_back(lookup_or_insert(m, s, d));
  endtask

  task automatic go_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    go_quiet();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Write one register; only called with nothing in flight
  task automatic write_reg(logic [kpht_pkg::CIDX_W-1:0] idx, logic [kpht_pkg::MULT_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      kpht_pkg::CFG_MULT: sh_mult = val;
      kpht_pkg::CFG_SIZE: sh_size = val[kpht_pkg::SIZE_W-1:0];
      kpht_pkg::CFG_KLEN: sh_klen = val[kpht_pkg::KLEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] mult, logic [31:0] size, logic [31:0] klen);
    drain();
    write_reg(kpht_pkg::CFG_MULT, mult);
    write_reg(kpht_pkg::CFG_SIZE, size);
    write_reg(kpht_pkg::CFG_KLEN, klen);
  endtask

  // Long receiver hold-off, counted in cycles
  always begin
    @(hold_start);
    hold_on <= 1'b1;
    repeat (hold_len) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // Check each result transfer and drive the stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, got st=%0d slot=%0d ord=%0d",
                 $time, status_o, slot_o, order_o);
        errors++;
      end else begin
        outcome_t e;
        e = pending_results.pop_front();
        if (status_o !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status_o);
          errors++;
        end
        if (slot_o !== e.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, e.slot, slot_o);
          errors++;
        end
        if (order_o !== e.ord) begin
          $display("%0t: order expected %0d actual %0d", $time, e.ord, order_o);
          errors++;
        end
      end
    end
    if (hold_on) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic test_basic_ops();
    logic [63:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    send_request(1'b0, a, b);               // lookup in empty table
    send_request(1'b1, a, b);               // insert
    send_request(1'b1, a, b);               // already there
    send_request(1'b0, a, b);               // found
    send_request(1'b0, b, a);               // swapped pair is another key
    send_request(1'b1, '0, '0);
    send_request(1'b1, '1, '1);
    send_request(1'b0, '1, '1);
    send_request(1'b1, '0, '1);
    send_request(1'b0, '1, '0);
  endtask

  task automatic test_unused_bases();
    set_config(32'd31, 32'd13, 32'd3);
    send_request(1'b1, 64'hAAAA_AAAA_AA12_3456, 64'h5555_5555_5500_00FF);
    // same low bytes, different upper bytes: must hit the same entry
    send_request(1'b0, 64'h0000_0000_0012_3456, 64'hFFFF_FFFF_FF00_00FF);
    send_request(1'b1, 64'h1234_5678_9A12_3456, 64'h0000_0000_0000_00FF);
  endtask

  task automatic test_full_table();
    // small table filled up, then inserts and lookups of an absent and a present key
    set_config(32'd1, 32'd3, 32'd1);
    for (int i = 0; i < 5; i++) send_request(1'b1, 64'(i), 64'(i + 7));
    send_request(1'b0, 64'd200, 64'd201);
    send_request(1'b0, 64'd1, 64'd8);
    // size zero acts as one slot, zero-length k-mers make every key equal
    set_config(32'hFFFF_FFFF, 32'd0, 32'd0);
    send_request(1'b1, 64'd9, 64'd9);
    send_request(1'b0, 64'd5, 64'd6);
    // oversize table and overlong k-mers clamp to the limits
    set_config(32'hFFFF_FFFF, 32'd2047, 32'd15);
    send_request(1'b1, '1, 64'd3);
    send_request(1'b0, '1, 64'd3);
  endtask

  task automatic test_random_phase(int idle, int stall, int count);
    logic [31:0] sizes [8] = '{2, 3, 7, 13, 61, 127, 1021, 1024};
    logic [31:0] mult;
    drain();
    send_idle_pct = idle;
    recv_stall_pct = stall;
    case ($urandom_range(3))
      0: mult = 32'd1;
      1: mult = 32'hFFFF_FFFF;
      default: mult = $urandom;
    endcase
    set_config(mult, sizes[$urandom_range(7)], $urandom_range(4) == 0 ? 8 : $urandom_range(1, 3));
    for (int i = 0; i < 32; i++) key_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8)
        send_request($urandom_range(1), key_pool[$urandom_range(31)],
                     key_pool[$urandom_range(31)]);
      else
        send_request($urandom_range(1), {$urandom, $urandom}, {$urandom, $urandom});
      // stretch of no idling in the middle of each phase
      if (i == count / 2) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      if (i == count / 2 + 30) begin
        send_idle_pct = idle;
        recv_stall_pct = stall;
      end
    end
  endtask

  task automatic test_back_pressure();
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(32'd5, 32'd7, 32'd1);
    hold_len = 4000;
    -> hold_start;
    for (int i = 0; i < 12; i++) send_request($urandom_range(1), $urandom, $urandom);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_basic_ops();
    test_unused_bases();
    test_full_table();
    test_random_phase(0, 0, 260);
    test_random_phase(46, 0, 260);
    test_random_phase(0, 46, 260);
    test_random_phase(20, 20, 260);
    test_back_pressure();
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS kmer_pair_hash_table_core");
    end else begin
      $display("FAIL kmer_pair_hash_table_core");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("FAIL kmer_pair_hash_table_core");
    $finish;
  end
endmodule
